// ===== src/sms_pkg.sv =====
package sms_pkg;

   // buffer size and stored value width
   localparam int MAX_ITEMS  = 64;
   localparam int VALUE_BITS = 32;
   localparam int PORT_BITS  = 32;
   localparam int IDX_BITS   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CNT_BITS   = $clog2(MAX_ITEMS + 1);

   typedef logic [VALUE_BITS-1:0]      value_type;
   typedef logic signed [PORT_BITS-1:0] port_value_type;
   typedef logic [IDX_BITS-1:0]        idx_type;
   typedef logic [CNT_BITS-1:0]        cnt_type;
   typedef logic [CNT_BITS:0]          run_width_type;
   typedef logic [CNT_BITS+1:0]        sum_type;

   typedef enum logic [2:0] {
      T_LOAD,
      T_SORT,
      T_EMIT_RD,
      T_EMIT_LD,
      T_EMIT_WAIT
   } top_state_type;

   typedef enum logic [1:0] {
      M_IDLE,
      M_PRIME,
      M_MERGE
   } merge_state_type;

   // memory accesses driven by the merge sequencer
   typedef struct packed {
      logic      we_a;
      logic      we_b;
      idx_type   waddr;
      value_type wdata;
      idx_type   raddr_p;
      idx_type   raddr_q;
   } merge_ctrl_type;

   // merge sequencer status
   typedef struct packed {
      logic busy;
      logic sel;
   } merge_stat_type;

   // port value to stored width, sign-extended or cut
   function automatic value_type widen(input port_value_type x);
      value_type r;
      int b;
      for (b = 0; b < VALUE_BITS; b++) begin
         r[b] = x[(b < PORT_BITS) ? b : PORT_BITS - 1];
      end
      return r;
   endfunction

   // stored value back to port width
   function automatic port_value_type narrow(input value_type v);
      port_value_type r;
      int b;
      for (b = 0; b < PORT_BITS; b++) begin
         r[b] = v[(b < VALUE_BITS) ? b : VALUE_BITS - 1];
      end
      return r;
   endfunction

   // smaller of a run bound and the set size
   function automatic cnt_type clamp(input sum_type s, input cnt_type n);
      cnt_type r;
      if (s > sum_type'(n)) begin
         r = n;
      end else begin
         r = s[CNT_BITS-1:0];
      end
      return r;
   endfunction

endpackage

// ===== src/sms_if.sv =====
interface sms_req_if;
   logic                         valid;
   logic                         ready;
   logic signed [sms_pkg::PORT_BITS-1:0] item_value;
   logic                         set_end;

   modport source (output valid, output item_value, output set_end, input ready);
   modport sink (input valid, input item_value, input set_end, output ready);
endinterface

interface sms_rsp_if;
   logic                         valid;
   logic                         ready;
   logic signed [sms_pkg::PORT_BITS-1:0] sorted_value;
   logic                         run_end;
   logic                         overflowed;

   modport source (output valid, output sorted_value, output run_end, output overflowed,
                   input ready);
   modport sink (input valid, input sorted_value, input run_end, input overflowed,
                 output ready);
endinterface

// ===== src/sms_ram.sv =====
module sms_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_p,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_q,
   output logic [WIDTH-1:0]         rd_data_p,
   output logic [WIDTH-1:0]         rd_data_q
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_p <= mem[rd_addr_p];
      rd_data_q <= mem[rd_addr_q];
   end

endmodule

// ===== src/sms_merge.sv =====
module sms_merge (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  sms_pkg::cnt_type        start_count,
   input  sms_pkg::value_type      a_rd_p,
   input  sms_pkg::value_type      a_rd_q,
   input  sms_pkg::value_type      b_rd_p,
   input  sms_pkg::value_type      b_rd_q,
   output sms_pkg::merge_ctrl_type ctrl,
   output sms_pkg::merge_stat_type stat
);

   sms_pkg::merge_state_type state_ff, state_in;
   sms_pkg::cnt_type         count_ff, count_in;
   sms_pkg::run_width_type   width_ff, width_in;
   sms_pkg::cnt_type         i_ff, i_in;
   sms_pkg::cnt_type         j_ff, j_in;
   sms_pkg::cnt_type         k_ff, k_in;
   sms_pkg::cnt_type         mid_ff, mid_in;
   sms_pkg::cnt_type         hi_ff, hi_in;
   logic                     src_ff, src_in;

   sms_pkg::value_type     head_p, head_q;
   logic                   take_p;
   sms_pkg::cnt_type       k_nx, mid_nx, hi_nx;
   sms_pkg::run_width_type width_nx;

   // heads of the two runs come from the source memory
   assign head_p = src_ff ? b_rd_p : a_rd_p;
   assign head_q = src_ff ? b_rd_q : a_rd_q;

   assign stat.busy = (state_ff != sms_pkg::M_IDLE);
   assign stat.sel  = src_ff;

   // pass and run sequencing, one merged item per cycle while merging
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      width_in = width_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      mid_in   = mid_ff;
      hi_in    = hi_ff;
      src_in   = src_ff;
      take_p   = 1'b0;
      k_nx     = sms_pkg::CNT_BITS'(k_ff + 1'b1);
      width_nx = sms_pkg::run_width_type'(width_ff << 1);
      mid_nx   = sms_pkg::clamp(sms_pkg::sum_type'(hi_ff) + sms_pkg::sum_type'(width_ff),
                                count_ff);
      hi_nx    = sms_pkg::clamp(sms_pkg::sum_type'(hi_ff) + sms_pkg::sum_type'(width_nx),
                                count_ff);
      ctrl.we_a    = 1'b0;
      ctrl.we_b    = 1'b0;
      ctrl.waddr   = k_ff[sms_pkg::IDX_BITS-1:0];
      ctrl.wdata   = head_q;
      ctrl.raddr_p = i_ff[sms_pkg::IDX_BITS-1:0];
      ctrl.raddr_q = j_ff[sms_pkg::IDX_BITS-1:0];

      case (state_ff)
         sms_pkg::M_IDLE: begin
            if (start) begin
               count_in = start_count;
               width_in = sms_pkg::run_width_type'(1);
               src_in   = 1'b0;
               if (start_count > sms_pkg::CNT_BITS'(1)) begin
                  state_in = sms_pkg::M_PRIME;
               end
            end
         end
         sms_pkg::M_PRIME: begin
            // first run pair of a pass
            mid_in = sms_pkg::clamp(sms_pkg::sum_type'(width_ff), count_ff);
            hi_in  = sms_pkg::clamp(sms_pkg::sum_type'(width_nx), count_ff);
            i_in   = '0;
            j_in   = mid_in;
            k_in   = '0;
            ctrl.raddr_p = '0;
            ctrl.raddr_q = mid_in[sms_pkg::IDX_BITS-1:0];
            state_in = sms_pkg::M_MERGE;
         end
         sms_pkg::M_MERGE: begin
            // left run wins ties, which keeps the sort stable
            take_p = (i_ff < mid_ff) &&
                     ((j_ff >= hi_ff) || ($signed(head_p) <= $signed(head_q)));
            ctrl.we_a  = src_ff;
            ctrl.we_b  = !src_ff;
            ctrl.wdata = take_p ? head_p : head_q;
            i_in = sms_pkg::CNT_BITS'(i_ff + sms_pkg::CNT_BITS'(take_p));
            j_in = sms_pkg::CNT_BITS'(j_ff + sms_pkg::CNT_BITS'(!take_p));
            k_in = k_nx;
            if (k_nx == hi_ff) begin
               if (hi_ff == count_ff) begin
                  // pass done: swap memories, double the run length
                  src_in   = !src_ff;
                  width_in = width_nx;
                  if (width_nx >= sms_pkg::run_width_type'(count_ff)) begin
                     state_in = sms_pkg::M_IDLE;
                  end else begin
                     state_in = sms_pkg::M_PRIME;
                  end
               end else begin
                  // next run pair follows without a gap
                  i_in   = hi_ff;
                  mid_in = mid_nx;
                  hi_in  = hi_nx;
                  j_in   = mid_nx;
               end
            end
            ctrl.raddr_p = i_in[sms_pkg::IDX_BITS-1:0];
            ctrl.raddr_q = j_in[sms_pkg::IDX_BITS-1:0];
         end
         default: begin
            state_in = sms_pkg::M_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sms_pkg::M_IDLE;
         src_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         src_ff   <= src_in;
      end
   end

   // run bounds and pointers
   always_ff @(posedge clock) begin
      count_ff <= count_in;
      width_ff <= width_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
      mid_ff   <= mid_in;
      hi_ff    <= hi_in;
   end

endmodule

// ===== src/stable_merge_sort.sv =====
// loading: one item per cycle, ready while no set is being sorted or emitted
// sort: ceil(log2 n) merge passes, one memory write per cycle while merging
// emit: read and load states register the first result after the sort, then each next
// result is loaded only once the one before has been taken
// reset clears the fill count, drop flag and control; result registers and memories keep their contents
module stable_merge_sort (
   input logic      clock,
   input logic      reset,
   sms_req_if.sink   req_chan,
   sms_rsp_if.source rsp_chan
);

   sms_pkg::top_state_type state_ff, state_in;
   sms_pkg::cnt_type       fill_ff, fill_in;
   logic                   drop_ff, drop_in;
   sms_pkg::cnt_type       emit_ff, emit_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   sms_pkg::port_value_type value_ff, value_in;
   logic                   run_end_ff, run_end_in;
   logic                   ovf_ff, ovf_in;

   logic                    take, full, emitting, load_we, start;
   sms_pkg::cnt_type        start_count;
   sms_pkg::idx_type        emit_addr, raddr_p;
   sms_pkg::merge_ctrl_type mctrl;
   sms_pkg::merge_stat_type mstat;
   sms_pkg::value_type      a_rd_p, a_rd_q, b_rd_p, b_rd_q, result_data;
   sms_pkg::value_type      a_wdata;
   sms_pkg::idx_type        a_waddr;

   assign req_chan.ready        = (state_ff == sms_pkg::T_LOAD);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.sorted_value = value_ff;
   assign rsp_chan.run_end      = run_end_ff;
   assign rsp_chan.overflowed   = ovf_ff;

   // loading into memory a
   assign take        = req_chan.valid && req_chan.ready;
   assign full        = (fill_ff == sms_pkg::CNT_BITS'(sms_pkg::MAX_ITEMS));
   assign load_we     = take && !full;
   assign start       = take && req_chan.set_end;
   assign start_count = full ? fill_ff : sms_pkg::CNT_BITS'(fill_ff + 1'b1);

   // read address: emit sequencer or merge sequencer
   assign emitting  = (state_ff == sms_pkg::T_EMIT_RD) || (state_ff == sms_pkg::T_EMIT_LD) ||
                      (state_ff == sms_pkg::T_EMIT_WAIT);
   assign emit_addr = (state_ff == sms_pkg::T_EMIT_WAIT) ?
                      sms_pkg::IDX_BITS'(emit_ff + 1'b1) : emit_ff[sms_pkg::IDX_BITS-1:0];
   assign raddr_p   = emitting ? emit_addr : mctrl.raddr_p;

   assign a_waddr = load_we ? fill_ff[sms_pkg::IDX_BITS-1:0] : mctrl.waddr;
   assign a_wdata = load_we ? sms_pkg::widen(req_chan.item_value) : mctrl.wdata;

   assign result_data = mstat.sel ? b_rd_p : a_rd_p;

   sms_ram #(
      .DEPTH (sms_pkg::MAX_ITEMS),
      .WIDTH (sms_pkg::VALUE_BITS)
   ) u_ram_a (
      .clock     (clock),
      .wr_en     (load_we || mctrl.we_a),
      .wr_addr   (a_waddr),
      .wr_data   (a_wdata),
      .rd_addr_p (raddr_p),
      .rd_addr_q (mctrl.raddr_q),
      .rd_data_p (a_rd_p),
      .rd_data_q (a_rd_q)
   );

   sms_ram #(
      .DEPTH (sms_pkg::MAX_ITEMS),
      .WIDTH (sms_pkg::VALUE_BITS)
   ) u_ram_b (
      .clock     (clock),
      .wr_en     (mctrl.we_b),
      .wr_addr   (mctrl.waddr),
      .wr_data   (mctrl.wdata),
      .rd_addr_p (raddr_p),
      .rd_addr_q (mctrl.raddr_q),
      .rd_data_p (b_rd_p),
      .rd_data_q (b_rd_q)
   );

   sms_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .start_count (start_count),
      .a_rd_p      (a_rd_p),
      .a_rd_q      (a_rd_q),
      .b_rd_p      (b_rd_p),
      .b_rd_q      (b_rd_q),
      .ctrl        (mctrl),
      .stat        (mstat)
   );

   // load, sort and emit sequencing
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      drop_in      = drop_ff;
      emit_in      = emit_ff;
      rsp_valid_in = rsp_valid_ff;
      value_in     = value_ff;
      run_end_in   = run_end_ff;
      ovf_in       = ovf_ff;

      case (state_ff)
         sms_pkg::T_LOAD: begin
            if (take) begin
               if (full) begin
                  drop_in = 1'b1;
               end else begin
                  fill_in = sms_pkg::CNT_BITS'(fill_ff + 1'b1);
               end
               if (req_chan.set_end) begin
                  emit_in  = '0;
                  state_in = sms_pkg::T_SORT;
               end
            end
         end
         sms_pkg::T_SORT: begin
            if (!mstat.busy) begin
               state_in = sms_pkg::T_EMIT_RD;
            end
         end
         sms_pkg::T_EMIT_RD: begin
            state_in = sms_pkg::T_EMIT_LD;
         end
         sms_pkg::T_EMIT_LD: begin
            rsp_valid_in = 1'b1;
            value_in     = sms_pkg::narrow(result_data);
            run_end_in   = (sms_pkg::CNT_BITS'(emit_ff + 1'b1) == fill_ff);
            ovf_in       = drop_ff;
            state_in     = sms_pkg::T_EMIT_WAIT;
         end
         sms_pkg::T_EMIT_WAIT: begin
            if (rsp_valid_ff && rsp_chan.ready) begin
               rsp_valid_in = 1'b0;
               if (run_end_ff) begin
                  fill_in  = '0;
                  drop_in  = 1'b0;
                  state_in = sms_pkg::T_LOAD;
               end else begin
                  emit_in  = sms_pkg::CNT_BITS'(emit_ff + 1'b1);
                  state_in = sms_pkg::T_EMIT_LD;
               end
            end
         end
         default: begin
            state_in = sms_pkg::T_LOAD;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sms_pkg::T_LOAD;
         fill_ff      <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // emit index and result payload
   always_ff @(posedge clock) begin
      emit_ff    <= emit_in;
      value_ff   <= value_in;
      run_end_ff <= run_end_in;
      ovf_ff     <= ovf_in;
   end

endmodule
